// ----- rtl/c3f_pkg.sv -----
// Shared types and constants for the 3x3 pixel filter.
`default_nettype none

package c3f_pkg;

  localparam int PIX_W       = 8;
  localparam int TAPS        = 3;
  localparam int COEF_W      = 8;
  localparam int PROD_W      = 17;
  localparam int MAG_W       = PROD_W - 1;
  localparam int SCALED_W    = MAG_W + 16;
  localparam int QUOT_W      = 13;
  localparam int CSUM_W      = 15;
  localparam int SUM_W       = 16;

  // floor(m / 9) == (m * 58255) >> 19 for every magnitude below 2^15
  localparam logic [15:0] RECIP_NINE  = 16'd58255;
  localparam int          RECIP_SHIFT = 19;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int COEF_ROW_W = 24;

  localparam logic [FW_W-1:0]       FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]       FRAME_HEIGHT_RST = 12'd480;
  localparam logic [COEF_ROW_W-1:0] COEF_ROW_RST     = 24'h010101;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_COEF_ROW_TOP    = 3'd2,
    REG_COEF_ROW_MIDDLE = 3'd3,
    REG_COEF_ROW_BOTTOM = 3'd4
  } cfg_reg_t;

  // one window column, index 0 is the top row
  typedef logic [TAPS-1:0][PIX_W-1:0] pix_col_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [TAPS-1:0] coef_col_t;

  typedef struct packed {
    logic adv;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic produce;
    logic last;
  } meta_t;

endpackage

`default_nettype wire

// ----- rtl/c3f_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module c3f_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c3f_cell.sv -----
// One window column cell: holds three pixels and forms its share of the sum.
`default_nettype none

module c3f_cell
  import c3f_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  pix_col_t                 col_in,
  input  coef_col_t                coef,
  output pix_col_t                 col_out,
  output logic signed [CSUM_W-1:0] col_sum
);

  pix_col_t                 pix;
  logic signed [PROD_W-1:0] prod      [TAPS];
  logic signed [PROD_W-1:0] prod_next [TAPS];
  logic [MAG_W-1:0]         mag       [TAPS];
  logic [SCALED_W-1:0]      scaled    [TAPS];
  logic [QUOT_W-2:0]        quot_mag  [TAPS];
  logic signed [QUOT_W-1:0] quot      [TAPS];
  logic signed [QUOT_W-1:0] quot_next [TAPS];
  logic signed [CSUM_W-1:0] sum_next;

  // take the column from the right-hand neighbour on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (ctrl.shift) begin
      pix <= col_in;
    end
  end

  assign col_out = pix;

  // pixel times signed coefficient
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      prod_next[t] = $signed({1'b0, pix[t]}) * coef[t];
    end
  end

  // divide each product by nine, truncating toward zero
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      mag[t] = prod[t][PROD_W-1] ? MAG_W'(-prod[t]) : prod[t][MAG_W-1:0];
      scaled[t] = mag[t] * RECIP_NINE;
      quot_mag[t] = scaled[t][RECIP_SHIFT +: QUOT_W-1];
      quot_next[t] = prod[t][PROD_W-1] ? -$signed({1'b0, quot_mag[t]})
                                       : $signed({1'b0, quot_mag[t]});
    end
  end

  // add up the three quotients of this column
  always_comb begin
    sum_next = '0;
    for (int t = 0; t < TAPS; t++) begin
      sum_next = sum_next + CSUM_W'(quot[t]);
    end
  end

  // advance the arithmetic stages
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      for (int t = 0; t < TAPS; t++) begin
        prod[t] <= prod_next[t];
        quot[t] <= quot_next[t];
      end
      col_sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/conv3x3_pixel_filter.sv -----
// 3x3 pixel filter: one pixel per clock in unless stalled, one result per interior pixel out.
// A result passes the input, cell pixel, product, quotient, column-sum and queue registers.
// Throughput: one pixel per clock while out_ready is high; the line store RAM
// (one read and one write port) and the three column cells all run at that rate.
// A two-entry output queue keeps input flowing while one result waits.
// Reset: counters, window, queue and registers return to defaults; no RAM clearing.
`default_nettype none

module conv3x3_pixel_filter
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIX_W-1:0]        pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] filtered_value,
  output logic                    frame_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NSTAGE = 4;

  logic [FW_W-1:0]       frame_width;
  logic [FH_W-1:0]       frame_height;
  logic [COEF_ROW_W-1:0] coef_row_top;
  logic [COEF_ROW_W-1:0] coef_row_middle;
  logic [COEF_ROW_W-1:0] coef_row_bottom;

  logic [WW-1:0]   eff_width;
  logic [FH_W-1:0] eff_height;
  logic [AW-1:0]   col_cnt;
  logic [FH_W-1:0] row_cnt;
  logic [WW-1:0]   col_plus;
  logic [FH_W-1:0] row_plus;
  logic            last_col;
  logic            last_row;
  logic            in_accept;
  logic            adv;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [AW-1:0]    s1_addr;
  meta_t            s1_meta;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [2*PIX_W-1:0]   ram_wdata;
  logic [2*PIX_W-1:0]   ram_rdata;

  logic [NSTAGE-1:0] pipe_valid;
  meta_t             meta_pipe [NSTAGE];

  cell_ctrl_t               cell_ctrl;
  pix_col_t                 new_col;
  pix_col_t                 cell_in   [TAPS];
  pix_col_t                 cell_out  [TAPS];
  coef_col_t                cell_coef [TAPS];
  logic signed [CSUM_W-1:0] col_sum   [TAPS];
  logic signed [SUM_W-1:0]  total;

  logic signed [SUM_W-1:0] q_val  [2];
  logic                    q_last [2];
  logic                    q_wr;
  logic                    q_rd;
  logic [1:0]              q_count;
  logic                    push;
  logic                    pop;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= FRAME_WIDTH_RST;
      frame_height    <= FRAME_HEIGHT_RST;
      coef_row_top    <= COEF_ROW_RST;
      coef_row_middle <= COEF_ROW_RST;
      coef_row_bottom <= COEF_ROW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:     frame_width     <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data[FH_W-1:0];
        REG_COEF_ROW_TOP:    coef_row_top    <= cfg_data[COEF_ROW_W-1:0];
        REG_COEF_ROW_MIDDLE: coef_row_middle <= cfg_data[COEF_ROW_W-1:0];
        REG_COEF_ROW_BOTTOM: coef_row_bottom <= cfg_data[COEF_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the frame size to what the line stores can hold
  always_comb begin
    if (frame_width < 11'd3) begin
      eff_width = WW'(3);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(frame_width);
    end
    eff_height = (frame_height < 12'd3) ? 12'd3 : frame_height;
  end

  // stall only when a finished result cannot enter a full queue
  assign adv       = !(pipe_valid[NSTAGE-1] && meta_pipe[NSTAGE-1].produce &&
                       q_count == 2'd2);
  assign in_ready  = adv;
  assign in_accept = in_valid && in_ready;

  assign col_plus = WW'(col_cnt) + WW'(1);
  assign row_plus = row_cnt + 12'd1;
  assign last_col = col_plus >= eff_width;
  assign last_row = row_plus >= eff_height;

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_plus;
      end else begin
        col_cnt <= col_cnt + AW'(1);
      end
    end
  end

  // hold the pixel while the line store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel        <= pixel;
      s1_addr         <= col_cnt;
      s1_meta.produce <= (row_cnt >= 12'd2) && (col_cnt >= AW'(2));
      s1_meta.last    <= last_col && last_row;
    end
  end

  // both line stores share one RAM: upper row in the high byte
  assign ram_re    = in_accept;
  assign ram_raddr = col_cnt;
  assign ram_we    = adv && s1_valid;
  assign ram_waddr = s1_addr;
  assign ram_wdata = {ram_rdata[PIX_W-1:0], s1_pixel};

  c3f_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // advance the valid and tag pipeline alongside the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (adv) begin
      pipe_valid <= {pipe_valid[NSTAGE-2:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_pipe[0] <= s1_meta;
      for (int k = 1; k < NSTAGE; k++) begin
        meta_pipe[k] <= meta_pipe[k-1];
      end
    end
  end

  // new right-hand column: upper store, middle store, incoming pixel
  assign new_col = {s1_pixel, ram_rdata[PIX_W-1:0], ram_rdata[2*PIX_W-1:PIX_W]};

  assign cell_ctrl.adv   = adv;
  assign cell_ctrl.shift = adv && s1_valid;

  // chain of column cells, data moving from right to left
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == TAPS - 1) begin : g_head
      assign cell_in[k] = new_col;
    end else begin : g_link
      assign cell_in[k] = cell_out[k+1];
    end

    assign cell_coef[k] = {coef_row_bottom[COEF_W*k +: COEF_W],
                           coef_row_middle[COEF_W*k +: COEF_W],
                           coef_row_top[COEF_W*k +: COEF_W]};

    c3f_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cell_ctrl),
      .col_in  (cell_in[k]),
      .coef    (cell_coef[k]),
      .col_out (cell_out[k]),
      .col_sum (col_sum[k])
    );
  end

  // combine the three column sums
  always_comb begin
    total = '0;
    for (int k = 0; k < TAPS; k++) begin
      total = total + SUM_W'(col_sum[k]);
    end
  end

  // two-entry output queue
  assign push = adv && pipe_valid[NSTAGE-1] && meta_pipe[NSTAGE-1].produce;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= 1'b0;
      q_rd    <= 1'b0;
      q_count <= '0;
    end else begin
      if (push) begin
        q_wr <= !q_wr;
      end
      if (pop) begin
        q_rd <= !q_rd;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_val[q_wr]  <= total;
      q_last[q_wr] <= meta_pipe[NSTAGE-1].last;
    end
  end

  assign out_valid      = q_count != 2'd0;
  assign filtered_value = q_val[q_rd];
  assign frame_last     = q_last[q_rd];

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 2'd2)
    else $error("output queue overfilled");

  // line store read never meets a write to the same column
  a_ram_hazard: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line store read and write collide");

  // last pixel of the frame returns the raster position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_col && last_row) |=> (col_cnt == '0 && row_cnt == '0))
    else $error("frame end did not reset position");

  // a result held back by a full queue stays in the last stage
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (pipe_valid[NSTAGE-1] && meta_pipe[NSTAGE-1].produce && !adv) |=>
    (pipe_valid[NSTAGE-1] && meta_pipe[NSTAGE-1].produce))
    else $error("stalled result lost");

endmodule

`default_nettype wire
